// ----- rtl/core/irs_pkg.sv -----
// Shared types and constants for the interval relation scan block.
// Command classes, relation and status codes, and default sizes.
// No dependencies.
package irs_pkg;

	localparam int DEF_CAPACITY  = 4096;
	localparam int DEF_TIME_BITS = 32;
	localparam int ANS_W         = 13;
	localparam int QUEUE_DEPTH   = 2;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_QUERY  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		OP_NOP       = 3'd0,
		OP_CLEAR     = 3'd1,
		OP_APPEND    = 3'd2,
		OP_BAD_ORDER = 3'd3,
		OP_QUERY     = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		REL_EQUALS      = 4'd0,
		REL_STARTS      = 4'd1,
		REL_STARTED     = 4'd2,
		REL_FINISHES    = 4'd3,
		REL_FINISHED    = 4'd4,
		REL_MEETS       = 4'd5,
		REL_MET         = 4'd6,
		REL_OVERLAPS    = 4'd7,
		REL_OVERLAPPED  = 4'd8,
		REL_CONTAINS    = 4'd9,
		REL_CONTAINED   = 4'd10,
		REL_PRECEDES    = 4'd11,
		REL_PRECEDED    = 4'd12,
		REL_STABBING    = 4'd13,
		REL_GEN_OVERLAP = 4'd14
	} rel_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ORDER = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// Classified command, front to back
	typedef struct packed {
		op_t  op;
		rel_t kind;
	} cmd_ctrl_t;

endpackage

// ----- rtl/core/interval_relation_scan.sv -----
// Top level of the interval relation scan block.
// Depends on irs_pkg, irs_front, irs_fifo and irs_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  input    | push / full        | func, relation_kind, lo_time, hi_time
//  result   | empty / pop        | answer, status
//  config   | cfg_we             | cfg_wdata (aggregate mode)
//
// Clear, append, ignored codes and a query of an empty table are answered in
// the cycle the back end takes them; any other query is paced by the single
// read port of the interval store: a start step, one read per entry, a drain of
// the compare and accumulate stages, then the push of the total.
// Items pass through the front register and then the command queue.
// Reset leaves the store undefined; only entries below the fill count are read.
// Either side stalls on its own: items queue up ahead of a busy back end,
// results queue up while pop is low.
module interval_relation_scan
	import irs_pkg::*;
#(
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             push,
	input  logic [1:0]       func,
	input  logic [3:0]       relation_kind,
	input  logic [31:0]      lo_time,
	input  logic [31:0]      hi_time,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output logic [ANS_W-1:0] answer,
	output logic [1:0]       status
);

	localparam int CTRL_W = $bits(cmd_ctrl_t);
	localparam int CMD_W  = CTRL_W + 2 * TIME_BITS;
	localparam int RES_W  = ANS_W + $bits(status_t);

	// front -> command queue
	logic                 f_push, f_full;
	cmd_ctrl_t            f_ctrl;
	logic [TIME_BITS-1:0] f_lo, f_hi;
	logic [CMD_W-1:0]     cmd_wdata, cmd_rdata;

	// command queue -> back
	logic                 c_empty, c_pop;
	cmd_ctrl_t            b_ctrl;
	logic [TIME_BITS-1:0] b_lo, b_hi;

	// back -> result queue
	logic                 r_push, r_full;
	logic [ANS_W-1:0]     r_answer;
	status_t              r_status;
	logic [RES_W-1:0]     res_wdata, res_rdata;

	irs_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.func          (func),
		.relation_kind (relation_kind),
		.lo_time       (lo_time),
		.hi_time       (hi_time),
		.full          (full),
		.q_push        (f_push),
		.q_full        (f_full),
		.q_ctrl        (f_ctrl),
		.q_lo          (f_lo),
		.q_hi          (f_hi)
	);

	assign cmd_wdata = {f_ctrl, f_lo, f_hi};

	irs_fifo #(
		.W(CMD_W)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (cmd_wdata),
		.full   (f_full),
		.pop    (c_pop),
		.rdata  (cmd_rdata),
		.empty  (c_empty)
	);

	assign {b_ctrl, b_lo, b_hi} = cmd_rdata;

	irs_back #(
		.CAPACITY  (CAPACITY),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd_empty  (c_empty),
		.cmd_ctrl   (b_ctrl),
		.cmd_lo     (b_lo),
		.cmd_hi     (b_hi),
		.cmd_pop    (c_pop),
		.res_full   (r_full),
		.res_push   (r_push),
		.res_answer (r_answer),
		.res_status (r_status)
	);

	// Result queue: the oldest waiting result sits on the ports
	assign res_wdata = {r_answer, r_status};

	irs_fifo #(
		.W(RES_W)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (r_push),
		.wdata  (res_wdata),
		.full   (r_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign {answer, status} = res_rdata;

endmodule

// ----- rtl/core/irs_fifo.sv -----
// Small register queue used between front and back and on the result side.
// Depends on irs_pkg (QUEUE_DEPTH).
module irs_fifo
	import irs_pkg::*;
#(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop)      count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wdata;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("fifo count above depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("fifo count missed a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("fifo pointers disagree with count");
`endif

endmodule

// ----- rtl/core/irs_front.sv -----
// Input stage: takes items, narrows times, classifies the function code.
// Depends on irs_pkg. Feeds the command queue.
module irs_front
	import irs_pkg::*;
#(
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [1:0]           func,
	input  logic [3:0]           relation_kind,
	input  logic [31:0]          lo_time,
	input  logic [31:0]          hi_time,
	output logic                 full,
	output logic                 q_push,
	input  logic                 q_full,
	output cmd_ctrl_t            q_ctrl,
	output logic [TIME_BITS-1:0] q_lo,
	output logic [TIME_BITS-1:0] q_hi
);

	logic                 v_s1;
	cmd_ctrl_t            ctrl_s1;
	logic [TIME_BITS-1:0] lo_s1, hi_s1;
	logic [TIME_BITS-1:0] lo_t, hi_t;
	cmd_ctrl_t            ctrl_d;
	logic                 accept;

	assign lo_t   = TIME_BITS'(lo_time);
	assign hi_t   = TIME_BITS'(hi_time);
	assign full   = v_s1 && q_full;
	assign accept = push && !full;

	always_comb begin
		ctrl_d.kind = rel_t'(relation_kind);
		unique case (func_t'(func))
			FUNC_CLEAR:  ctrl_d.op = OP_CLEAR;
			FUNC_APPEND: ctrl_d.op = (lo_t > hi_t) ? OP_BAD_ORDER : OP_APPEND;
			FUNC_QUERY:  ctrl_d.op = OP_QUERY;
			default:     ctrl_d.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_d;
			lo_s1   <= lo_t;
			hi_s1   <= hi_t;
		end
	end

	assign q_push = v_s1;
	assign q_ctrl = ctrl_s1;
	assign q_lo   = lo_s1;
	assign q_hi   = hi_s1;

endmodule

// ----- rtl/core/irs_back.sv -----
// Execution side: interval store, fill count, mode register and query scan.
// Depends on irs_pkg. Pops the command queue, pushes the result queue.
module irs_back
	import irs_pkg::*;
#(
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 cmd_empty,
	input  cmd_ctrl_t            cmd_ctrl,
	input  logic [TIME_BITS-1:0] cmd_lo,
	input  logic [TIME_BITS-1:0] cmd_hi,
	output logic                 cmd_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output logic [ANS_W-1:0]     res_answer,
	output status_t              res_status
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t               state_q;
	logic                 mode_q;
	logic [CNT_W-1:0]     fill_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [ANS_W-1:0]     acc_q;
	logic [TIME_BITS-1:0] qs_q, qe_q;
	rel_t                 kind_q;

	logic [2*TIME_BITS-1:0] store_q [CAPACITY];

	logic                   v_s1, v_s2, match_s2;
	logic [IDX_W-1:0]       idx_s1, idx_s2;
	logic [2*TIME_BITS-1:0] ent_s1;

	logic is_full, start_scan, do_cmd, do_append, issue, last_issue, fin_push;

	function automatic logic rel_holds(rel_t k, logic [TIME_BITS-1:0] s,
			logic [TIME_BITS-1:0] e, logic [TIME_BITS-1:0] qs, logic [TIME_BITS-1:0] qe);
		logic r;
		unique case (k)
			REL_EQUALS:      r = (s == qs) && (e == qe);
			REL_STARTS:      r = (s == qs) && (e > qe);
			REL_STARTED:     r = (s == qs) && (e < qe);
			REL_FINISHES:    r = (e == qe) && (s < qs);
			REL_FINISHED:    r = (e == qe) && (s > qs);
			REL_MEETS:       r = (s == qe);
			REL_MET:         r = (e == qs);
			REL_OVERLAPS:    r = (qs < s) && (s < qe) && (qe < e);
			REL_OVERLAPPED:  r = (s < qs) && (qs < e) && (e < qe);
			REL_CONTAINS:    r = (s > qs) && (e < qe);
			REL_CONTAINED:   r = (s < qs) && (e > qe);
			REL_PRECEDES:    r = (s > qe);
			REL_PRECEDED:    r = (e < qs);
			REL_STABBING:    r = (s <= qs) && (qs <= e);
			REL_GEN_OVERLAP: r = (s <= qe) && (qs <= e);
			default:         r = 1'b0;
		endcase
		return r;
	endfunction

	assign is_full    = (fill_q >= CNT_W'(CAPACITY));
	assign start_scan = (cmd_ctrl.op == OP_QUERY) && (fill_q != '0);
	assign do_cmd     = (state_q == S_IDLE) && !cmd_empty && (start_scan || !res_full);
	assign do_append  = do_cmd && (cmd_ctrl.op == OP_APPEND) && !is_full;
	assign issue      = (state_q == S_SCAN);
	assign last_issue = issue && ((CNT_W'(rd_idx_q) + CNT_W'(1)) == fill_q);
	assign fin_push   = (state_q == S_FINISH) && !v_s1 && !v_s2 && !res_full;
	assign cmd_pop    = do_cmd;

	always_comb begin
		res_push   = fin_push || (do_cmd && !start_scan);
		res_answer = '0;
		res_status = ST_OK;
		if (fin_push) begin
			res_answer = acc_q;
		end else begin
			unique case (cmd_ctrl.op)
				OP_APPEND: begin
					if (is_full) res_status = ST_FULL;
					else         res_answer = ANS_W'(fill_q);
				end
				OP_BAD_ORDER: res_status = ST_BAD_ORDER;
				default:      res_answer = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= 1'b0;
			fill_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (do_cmd && cmd_ctrl.op == OP_CLEAR) fill_q <= '0;
			else if (do_append)                     fill_q <= fill_q + CNT_W'(1);
			unique case (state_q)
				S_IDLE:   if (do_cmd && start_scan) state_q <= S_SCAN;
				S_SCAN:   if (last_issue) state_q <= S_FINISH;
				S_FINISH: if (fin_push) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Scan datapath: read, compare, accumulate
	always_ff @(posedge clk) begin
		if (do_cmd && start_scan) begin
			qs_q     <= cmd_lo;
			qe_q     <= cmd_hi;
			kind_q   <= cmd_ctrl.kind;
			rd_idx_q <= '0;
			acc_q    <= '0;
		end else begin
			if (issue) rd_idx_q <= rd_idx_q + IDX_W'(1);
			if (v_s2 && match_s2) begin
				if (mode_q) acc_q <= acc_q + ANS_W'(1);
				else        acc_q <= acc_q ^ ANS_W'(idx_s2);
			end
		end
		if (issue) begin
			ent_s1 <= store_q[rd_idx_q];
			idx_s1 <= rd_idx_q;
		end
		match_s2 <= rel_holds(kind_q, ent_s1[2*TIME_BITS-1:TIME_BITS],
			ent_s1[TIME_BITS-1:0], qs_q, qe_q);
		idx_s2   <= idx_s1;
		if (do_append) store_q[fill_q[IDX_W-1:0]] <= {cmd_lo, cmd_hi};
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");
	a_push_drained: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!v_s1 && !v_s2 && !res_full))
		else $error("result pushed with scan in flight or queue full");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (CNT_W'(rd_idx_q) < fill_q))
		else $error("scan index beyond fill count");
	a_fill_stable_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> $stable(fill_q))
		else $error("fill count changed during scan");
`endif

endmodule
